### sv/wsm_pkg.sv
`timescale 1ns / 1ps

package wsm_pkg;

  localparam int unsigned MAX_PATTERN_WORDS = 32;
  localparam int unsigned IDX_W             = $clog2(MAX_PATTERN_WORDS);
  localparam int unsigned WORD_W            = 64;
  localparam int unsigned CNT_W             = 17;
  localparam int unsigned LEN_W             = 6;
  localparam logic [CNT_W-1:0] TEXT_CAP     = 17'd65536;

  // Packed widths of the stream payloads, padded to whole bytes
  localparam int unsigned IN_FIELDS_W  = IDX_W + WORD_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 1 + 3 * CNT_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_TEXT     = 2'd1,
    OP_NEW_TEXT = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic shift_word;   // text item: words move one cell further
    logic clear_words;  // new text: window goes to zero
    logic rotate_pat;   // pattern moves one cell for a length change
  } cell_ctrl_t;

endpackage

### sv/wsm_cell.sv
`timescale 1ns / 1ps

module wsm_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wsm_pkg::cell_ctrl_t        ctrl,
  input  logic                       load_en,
  input  logic [wsm_pkg::WORD_W-1:0] load_code,
  input  logic [wsm_pkg::WORD_W-1:0] word_in,
  input  logic [wsm_pkg::WORD_W-1:0] pat_in,
  output logic [wsm_pkg::WORD_W-1:0] word_out,
  output logic [wsm_pkg::WORD_W-1:0] pat_out,
  output logic                       eq
);

  logic [wsm_pkg::WORD_W-1:0] word_r;
  logic [wsm_pkg::WORD_W-1:0] pat_r;

  // window word, reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else if (ctrl.clear_words) begin
      word_r <= '0;
    end else if (ctrl.shift_word) begin
      word_r <= word_in;
    end
  end

  // pattern word, no reset
  always_ff @(posedge clk) begin
    if (ctrl.rotate_pat) begin
      pat_r <= pat_in;
    end else if (load_en) begin
      pat_r <= load_code;
    end
  end

  // compare against the word that enters this cell
  assign eq       = (word_in == pat_r);
  assign word_out = word_r;
  assign pat_out  = pat_r;

endmodule

### sv/word_sequence_matcher_unit.sv
`timescale 1ns / 1ps

// Word sequence matcher.
// Input stream: in_tuser carries the op (load pattern word, text word,
// new text); in_tdata carries pattern_index and word_code. Every accepted
// item gives exactly one result item on the out_ stream.
// Result: match flag, 1-based match_start, running match_count and
// words_seen, both counters saturating at 65536.
// The pattern length is written on cfg_wr_en / cfg_wr_data (1..32, 0 acts
// as 1, larger values as 32).
// out_tvalid rises in the cycle after input accept. Throughput: one item per
// cycle while no ring turn or receiver stall holds in_tready low; the output
// register is refilled in the cycle it is drained. A length write moves the
// stored pattern around the cell ring one cell per cycle, so in_tready stays
// low until the ring has turned by the old-to-new length distance, modulo 32.
// Reset: window and counters cleared, length 1, out_tvalid low; the pattern
// store is not cleared and must be loaded before use.
// Receiver stall: the result holds in the output register and in_tready
// drops until it is taken.
module word_sequence_matcher_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [4:0] pattern_index, [68:5] word_code, rest zero
  input  logic [wsm_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] match, [17:1] match_start, [34:18] match_count, [51:35] words_seen
  output logic [wsm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [wsm_pkg::LEN_W-1:0]      cfg_wr_data
);

  localparam int unsigned N  = wsm_pkg::MAX_PATTERN_WORDS;
  localparam int unsigned IW = wsm_pkg::IDX_W;
  localparam int unsigned WW = wsm_pkg::WORD_W;
  localparam int unsigned CW = wsm_pkg::CNT_W;

  wsm_pkg::op_t          in_op;
  logic [IW-1:0]         in_idx;
  logic [WW-1:0]         in_code;
  logic                  in_acc;

  // active length minus one; also the alignment target of the pattern ring
  logic [IW-1:0]         len_m1_r;
  logic [IW-1:0]         len_m1_nxt;
  logic [IW-1:0]         cfg_len_m1;
  // ring steps still owed after length writes
  logic [IW-1:0]         rot_r;
  logic [IW-1:0]         rot_nxt;
  logic [IW-1:0]         rot_base;
  logic                  rotating;

  logic [CW-1:0]         pos_r;
  logic [CW-1:0]         pos_nxt;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         cnt_nxt;

  logic                  out_valid_r;
  logic [wsm_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [wsm_pkg::OUT_DATA_W-1:0] out_data_nxt;

  wsm_pkg::cell_ctrl_t   ctrl;
  logic [IW-1:0]         load_cell;
  logic [WW-1:0]         word_link [N+1];
  logic [WW-1:0]         pat_link  [N];
  logic [N-1:0]          cell_eq;
  logic [N-1:0]          cell_active;

  logic                  is_text;
  logic                  window_hit;
  logic                  hit;
  logic [CW-1:0]         start;

  assign in_op   = wsm_pkg::op_t'(in_tuser);
  assign in_idx  = in_tdata[IW-1:0];
  assign in_code = in_tdata[IW+WW-1:IW];

  assign rotating  = (rot_r != '0);
  assign in_tready = !rotating && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign is_text   = in_acc && (in_op == wsm_pkg::OP_TEXT);

  // clamp the written length into 1..N, kept as length minus one
  always_comb begin
    priority if (cfg_wr_data == '0) begin
      cfg_len_m1 = '0;
    end else if (cfg_wr_data >= wsm_pkg::LEN_W'(N)) begin
      cfg_len_m1 = IW'(N - 1);
    end else begin
      cfg_len_m1 = IW'(cfg_wr_data - 1'b1);
    end
  end

  // Cell c holds pattern word (len-1-c) mod N. A length change by d needs
  // the ring turned d cells; writes that come in a row add up.
  always_comb begin
    rot_base   = rotating ? (rot_r - 1'b1) : rot_r;
    rot_nxt    = rot_base;
    len_m1_nxt = len_m1_r;
    if (cfg_wr_en) begin
      rot_nxt    = rot_base + (cfg_len_m1 - len_m1_r);
      len_m1_nxt = cfg_len_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_m1_r <= '0;
      rot_r    <= '0;
    end else begin
      len_m1_r <= len_m1_nxt;
      rot_r    <= rot_nxt;
    end
  end

  always_comb begin
    ctrl.shift_word  = is_text;
    ctrl.clear_words = in_acc && (in_op == wsm_pkg::OP_NEW_TEXT);
    ctrl.rotate_pat  = rotating;
  end

  // pattern index i lands in cell (len-1-i) mod N
  assign load_cell = len_m1_r - in_idx;

  assign word_link[0] = in_code;

  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int unsigned PREV = (k + N - 1) % N;

    wsm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .load_en   (in_acc && (in_op == wsm_pkg::OP_LOAD) && (load_cell == IW'(k))),
      .load_code (in_code),
      .word_in   (word_link[k]),
      .pat_in    (pat_link[PREV]),
      .word_out  (word_link[k+1]),
      .pat_out   (pat_link[k]),
      .eq        (cell_eq[k])
    );

    assign cell_active[k] = (IW'(k) <= len_m1_r);
  end

  // the last cell's word leaves the window
  logic [WW-1:0] dropped_word;
  assign dropped_word = word_link[N];

  always_comb begin
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      unique case (in_op)
        wsm_pkg::OP_TEXT: begin
          if (pos_r < wsm_pkg::TEXT_CAP) begin
            pos_nxt = pos_r + 1'b1;
          end
          if (hit && (cnt_r < wsm_pkg::TEXT_CAP)) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        wsm_pkg::OP_NEW_TEXT: begin
          pos_nxt = '0;
          cnt_nxt = '0;
        end
        wsm_pkg::OP_LOAD,
        wsm_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // window compare uses the position after this word is counted
  always_comb begin
    logic [CW-1:0] pos_text;
    pos_text   = (pos_r < wsm_pkg::TEXT_CAP) ? (pos_r + 1'b1) : pos_r;
    window_hit = &(cell_eq | ~cell_active);
    hit        = is_text && window_hit && (pos_text > CW'(len_m1_r));
    start      = hit ? (pos_text - CW'(len_m1_r)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cnt_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[wsm_pkg::OUT_FIELDS_W-1:0] = {pos_nxt, cnt_nxt, start, hit};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r ^ {wsm_pkg::OUT_DATA_W{1'b0 & dropped_word[0]}};

endmodule

### sv/wsm_checker.sv
`timescale 1ns / 1ps

module wsm_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [wsm_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic                      m;
  logic [wsm_pkg::CNT_W-1:0] m_start;
  logic [wsm_pkg::CNT_W-1:0] m_count;
  logic [wsm_pkg::CNT_W-1:0] m_seen;

  assign m       = out_tdata[0];
  assign m_start = out_tdata[wsm_pkg::CNT_W:1];
  assign m_count = out_tdata[2*wsm_pkg::CNT_W:wsm_pkg::CNT_W+1];
  assign m_seen  = out_tdata[3*wsm_pkg::CNT_W:2*wsm_pkg::CNT_W+1];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_start_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && m |-> (m_start != '0) && (m_start <= m_seen) && (m_count != '0))
    else $error("match start or count out of range");

  a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !m |-> (m_start == '0))
    else $error("start given without match");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (m_seen <= wsm_pkg::TEXT_CAP) && (m_count <= m_seen))
    else $error("counter beyond limit");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind word_sequence_matcher_unit wsm_checker u_wsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/sv/tb_word_sequence_matcher_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the word sequence matcher. A scoreboard model tracks
// pattern store, recent-word window and both counters, predicts one result per
// accepted item and checks the out_ stream against it in order.
module tb_word_sequence_matcher_unit;
  import wsm_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;  // cycles with no handshake at all
  localparam int unsigned RANDOM_ITEMS = 1200;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] start;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] seen;
  } match_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [4:0] pattern_index, [68:5] word_code
  logic [1:0]            in_tuser = '0;   // [1:0] op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [0] match, [17:1] start, [34:18] count,
                                          // [51:35] words_seen
  logic                  cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]      cfg_wr_data = '0;

  // Scoreboard model state
  logic [WORD_W-1:0] pat_mem [MAX_PATTERN_WORDS];
  logic [WORD_W-1:0] win [MAX_PATTERN_WORDS];   // entry 0 is the newest word
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  found;
  logic [LEN_W-1:0]  len_cfg;
  match_result_t     pending_q [$];

  // Stimulus-side view of the pattern, used to build matching runs
  logic [WORD_W-1:0] plan_pat [MAX_PATTERN_WORDS];
  int unsigned       plan_len = 1;
  logic [WORD_W-1:0] vocab [4];

  bit          quiet = 1'b0;   // no gaps on either side while set
  int unsigned ready_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned fail_count = 0;
  int unsigned phases = 0;

  word_sequence_matcher_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // 0 behaves as 1, anything above the store depth as the full depth
  function automatic int unsigned eff_length(logic [LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_PATTERN_WORDS) return MAX_PATTERN_WORDS;
    return v;
  endfunction

  // One model step: update state for the item, return the result it produces
  function automatic match_result_t predict_match(op_t op, logic [IDX_W-1:0] idx,
                                                  logic [WORD_W-1:0] code);
    match_result_t r;
    int unsigned   n;
    bit            same;
    int            k;
    r = '0;
    case (op)
      OP_LOAD: pat_mem[idx] = code;
      OP_TEXT: begin
        n = eff_length(len_cfg);
        for (k = MAX_PATTERN_WORDS - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = code;
        if (pos < TEXT_CAP) pos++;
        // too few words since text start: never a match
        same = (pos >= n);
        if (same) begin
          for (k = 0; k < n; k++) if (win[k] != pat_mem[n-1-k]) same = 1'b0;
        end
        if (same) begin
          r.hit   = 1'b1;
          r.start = pos - CNT_W'(n) + 1'b1;  // saturated position still used
          if (found < TEXT_CAP) found++;
        end
      end
      OP_NEW_TEXT: begin
        for (k = 0; k < MAX_PATTERN_WORDS; k++) win[k] = '0;
        pos   = '0;
        found = '0;
      end
      default: ;  // unused op: nothing changes
    endcase
    r.count = found;
    r.seen  = pos;
    return r;
  endfunction

  // Monitor: model update on input accept, in-order compare on output accept
  always @(posedge clk) begin
    match_result_t got;
    match_result_t want;
    bit            moved;
    moved = 1'b0;
    if (!rst_n) begin
      for (int k = 0; k < MAX_PATTERN_WORDS; k++) win[k] = '0;
      pos     = '0;
      found   = '0;
      len_cfg = LEN_W'(1);
    end else begin
      if (cfg_wr_en) begin
        len_cfg = cfg_wr_data;
        moved   = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        pending_q.push_back(predict_match(op_t'(in_tuser), in_tdata[IDX_W-1:0],
                                          in_tdata[IDX_W +: WORD_W]));
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got.hit   = out_tdata[0];
        got.start = out_tdata[1 +: CNT_W];
        got.count = out_tdata[1 + CNT_W +: CNT_W];
        got.seen  = out_tdata[1 + 2*CNT_W +: CNT_W];
        if (got.hit === 1'b1) hits_seen++;
        if (pending_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result match=%0b start=%0d count=%0d seen=%0d",
                     got.hit, got.start, got.count, got.seen);
        end else begin
          want = pending_q.pop_front();
          if (got.hit !== want.hit || got.start !== want.start ||
              got.count !== want.count || got.seen !== want.seen) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: result %0d exp match=%0b start=%0d count=%0d seen=%0d",
                       results_checked, want.hit, want.start, want.count, want.seen);
              $display("       got match=%0b start=%0d count=%0d seen=%0d",
                       got.hit, got.start, got.count, got.seen);
            end
          end
        end
        results_checked++;
        ready_hold = quiet ? 0 : $urandom_range(0, 8);
        moved = 1'b1;
      end
      // watchdog
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
          $display("tb_word_sequence_matcher_unit NOT OK");
          $finish;
        end
      end
    end
  end

  // Receiver: after each taken result, hold ready low for the drawn cycles
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      out_tready <= 1'b0;
      ready_hold--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Entered and left at a falling edge; valid stays up when the next item follows at once
  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] code);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({code, idx});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_word(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] code);
    plan_pat[idx] = code;
    send_item(OP_LOAD, idx, code);
  endtask

  task automatic send_text(logic [WORD_W-1:0] code);
    send_item(OP_TEXT, IDX_W'($urandom), code);
  endtask

  // Length write only once every result is back and the block has settled
  task automatic write_length(logic [LEN_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    plan_len = eff_length(v);
  endtask

  // Whole pattern in order; a broken run flips one of its words
  task automatic send_pattern_run(bit broken);
    int bad_at;
    bad_at = broken ? int'($urandom_range(0, plan_len - 1)) : -1;
    for (int k = 0; k < plan_len; k++)
      send_text(k == bad_at ? ~plan_pat[k] : plan_pat[k]);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
    return vocab[$urandom_range(0, 3)];
  endfunction

  // Extreme codes, every op, short text, overlap, mid-text pattern change
  task automatic test_directed_cases();
    load_word(5'd0, '1);
    load_word(5'd1, '0);
    load_word(5'd2, '1);
    load_word(5'd31, 64'h5555_5555_5555_5555);
    send_text('1);                                   // length 1 hit at word 1
    send_text(64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_NONE, 5'h1F, 64'hFFFF_0000_FFFF_0000);  // counters hold
    send_item(OP_NEW_TEXT, '0, '0);
    write_length(6'd3);
    send_text('1);
    send_text('0);                                   // still too few words
    send_text('1);                                   // hit, start 1
    send_text('0);
    send_text('1);                                   // overlapping hit, start 3
    load_word(5'd1, '1);                             // pattern change mid-text
    send_text('1);
    send_text('1);
    write_length(6'd0);                              // acts as length 1
    send_text('1);
    send_text('0);
  endtask

  // Phases of well-formed runs mixed with noise, each with its own length
  task automatic test_random_traffic();
    logic [LEN_W-1:0] corner_len [5];
    logic [LEN_W-1:0] v;
    int unsigned      stop_at;
    int unsigned      r;
    corner_len = '{6'd1, 6'd32, 6'd0, 6'd33, 6'd63};
    vocab = '{'0, '1, {$urandom, $urandom}, {$urandom, $urandom}};
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      v = (phases < 5) ? corner_len[phases] : LEN_W'($urandom_range(0, 63));
      quiet = ($urandom_range(0, 3) == 0);
      write_length(v);
      if (phases == 0) begin
        // fill the whole store before any longer compare can read it
        for (int k = 0; k < MAX_PATTERN_WORDS; k++)
          load_word(IDX_W'(k), {$urandom, $urandom});
      end else if ($urandom_range(0, 2) == 0) begin
        for (int k = 0; k < plan_len; k++) load_word(IDX_W'(k), pick_word());
      end
      if ($urandom_range(0, 1) == 1) send_item(OP_NEW_TEXT, IDX_W'($urandom), pick_word());
      repeat ($urandom_range(4, 8)) begin
        r = $urandom_range(0, 99);
        if (r < 50)      send_pattern_run($urandom_range(0, 5) == 0);
        else if (r < 75) send_text(pick_word());
        else if (r < 83) send_item(OP_NONE, IDX_W'($urandom), {$urandom, $urandom});
        else if (r < 91) load_word(IDX_W'($urandom), pick_word());
        else if (r < 95) send_item(OP_NEW_TEXT, IDX_W'($urandom), {$urandom, $urandom});
        else             send_text({$urandom, $urandom});
      end
      phases++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_random_traffic();

    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("%0d items sent, %0d results checked, %0d matches, %0d failures",
             items_sent, results_checked, hits_seen, fail_count);
    $display("%0d length phases incl. 0, 1, 32, 33, 63; overlapping and broken runs,",
             phases);
    $display("mid-text pattern loads, new-text items and unused ops under random stalls");
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("tb_word_sequence_matcher_unit OK");
    end else begin
      $display("tb_word_sequence_matcher_unit NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
sv/wsm_pkg.sv
sv/wsm_cell.sv
sv/word_sequence_matcher_unit.sv
sv/wsm_checker.sv
tb/sv/tb_word_sequence_matcher_unit.sv
